[hdl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: command codes,
// field widths and the packed layout of one result.
// ----------------------------------------------------------------------------
package deq_pkg;

  // command codes carried on the request side tuser
  typedef enum logic [2:0] {
    CMD_QUERY      = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } cmd_t;

  localparam int VALUE_W     = 32;
  localparam int CMD_W       = 3;
  localparam int COUNT_OUT_W = 11;
  localparam int S_TDATA_W   = 32;
  localparam int M_TDATA_W   = 112;

  // returned for front, back and a failed pop when nothing is stored
  localparam logic [VALUE_W-1:0] EMPTY_MARK = 32'hFFFF_FFFF;

  // one result, first field in the highest bits
  typedef struct packed {
    logic [1:0]             pad;
    logic [VALUE_W-1:0]     back_value;
    logic [VALUE_W-1:0]     front_value;
    logic                   is_empty;
    logic [COUNT_OUT_W-1:0] count;
    logic                   overflow;
    logic                   pop_ok;
    logic [VALUE_W-1:0]     popped_value;
  } result_t;

endpackage

[hdl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of 32-bit signed values held in a ring buffer memory.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ group: s_tuser carries the command (query, push
//   front, push back, pop front, pop back; codes 5 to 7 act as query) and
//   s_tdata the value to push. Every request yields exactly one result on the
//   m_ group: popped value, pop and overflow flags, count, empty flag and the
//   front and back values after the request (-1 when the queue is empty).
//   The front and back elements are kept in registers; the ring memory is
//   written on a push and read only when a pop exposes a new end element.
//   An accepted request moves to S_DONE, where its result is registered
//   into m_tdata; a pop that leaves the queue non-empty passes S_LOAD first,
//   since the new end element must come through the single registered
//   memory read port. One request is handled at a time; the next is taken
//   only in S_IDLE, even while the previous result still waits on the m_
//   side; that request's result is held until the output register frees up.
//   Reset empties the queue at once (head and count cleared); no clearing
//   pass over the memory is needed. A push to a full queue is dropped and
//   flagged as overflow; a pop from an empty queue returns -1 with pop_ok low.
// ----------------------------------------------------------------------------
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
  input  logic [CMD_W-1:0]     s_tuser,   // [2:0] command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [31:0] popped_value, [32] pop_ok, [33] overflow, [44:34] count,
  // [45] is_empty, [77:46] front_value, [109:78] back_value, [111:110] zero
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int OW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DONE
  } state_t;

  state_t             state;
  logic [AW-1:0]      head;
  logic [CW-1:0]      count;
  logic [VALUE_W-1:0] front_reg;
  logic [VALUE_W-1:0] back_reg;
  logic [VALUE_W-1:0] popped_reg;
  logic               pop_ok_reg;
  logic               overflow_reg;
  logic               load_front;

  cmd_t               cmd;
  logic               accept;
  logic               full;
  logic [AW-1:0]      head_dec;
  logic [AW-1:0]      head_inc;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic [OW-1:0]      count_ext;
  result_t            res;

  // slot at head plus offset, offset never above the capacity
  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
                                            input logic [CW-1:0] offset);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(offset);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  assign cmd      = cmd_t'(s_tuser);
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign full     = (count >= CW'(CAPACITY));
  assign head_dec = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);
  assign head_inc = (head == AW'(CAPACITY - 1)) ? '0 : head + AW'(1);

  // memory access for the accepted request
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = head_dec;
    rd_en   = 1'b0;
    rd_addr = head_inc;
    if (accept) begin
      unique case (cmd)
        CMD_PUSH_FRONT: begin
          wr_en   = !full;
          wr_addr = head_dec;
        end
        CMD_PUSH_BACK: begin
          wr_en   = !full;
          wr_addr = slot_at(head, count);
        end
        CMD_POP_FRONT: begin
          rd_en   = (count > CW'(1));
          rd_addr = head_inc;
        end
        CMD_POP_BACK: begin
          rd_en   = (count > CW'(1));
          rd_addr = slot_at(head, count - CW'(2));
        end
        default: begin
        end
      endcase
    end
  end

  deq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (s_tdata[VALUE_W-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result fields from the state after the request
  assign count_ext = OW'(count);
  always_comb begin
    res              = '0;
    res.popped_value = popped_reg;
    res.pop_ok       = pop_ok_reg;
    res.overflow     = overflow_reg;
    res.count        = count_ext[COUNT_OUT_W-1:0];
    res.is_empty     = (count == '0);
    res.front_value  = (count == '0) ? EMPTY_MARK : front_reg;
    res.back_value   = (count == '0) ? EMPTY_MARK : back_reg;
  end

  // sequencer, queue state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // output valid: set when a result is loaded, cleared when taken
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            popped_reg   <= '0;
            pop_ok_reg   <= 1'b0;
            overflow_reg <= 1'b0;
            state        <= S_DONE;
            unique case (cmd)
              CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (full) begin
                  overflow_reg <= 1'b1;
                end else begin
                  count <= count + CW'(1);
                  if (cmd == CMD_PUSH_FRONT) begin
                    head      <= head_dec;
                    front_reg <= s_tdata[VALUE_W-1:0];
                    if (count == '0) begin
                      back_reg <= s_tdata[VALUE_W-1:0];
                    end
                  end else begin
                    back_reg <= s_tdata[VALUE_W-1:0];
                    if (count == '0) begin
                      front_reg <= s_tdata[VALUE_W-1:0];
                    end
                  end
                end
              end
              CMD_POP_FRONT, CMD_POP_BACK: begin
                if (count == '0) begin
                  popped_reg <= EMPTY_MARK;
                end else begin
                  pop_ok_reg <= 1'b1;
                  count      <= count - CW'(1);
                  load_front <= (cmd == CMD_POP_FRONT);
                  if (cmd == CMD_POP_FRONT) begin
                    popped_reg <= front_reg;
                    head       <= head_inc;
                  end else begin
                    popped_reg <= back_reg;
                  end
                  if (count > CW'(1)) begin
                    state <= S_LOAD;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_LOAD: begin
          // new end element arrives from the memory
          if (load_front) begin
            front_reg <= rd_data;
          end else begin
            back_reg <= rd_data;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= M_TDATA_W'(res);
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // a push that fits grows the queue by one
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) && !full
    |=> count == $past(count) + CW'(1))
    else $error("push did not grow the queue");

  // a pop on a non-empty queue shrinks it by one
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) && count != '0
    |=> count == $past(count) - CW'(1))
    else $error("pop did not shrink the queue");

  // a pop on an empty queue leaves head and count alone
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) && count == '0
    |=> count == '0 && head == $past(head))
    else $error("pop on empty queue changed state");

  // memory data is consumed only after a read was issued
  a_load_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |-> $past(rd_en))
    else $error("load without a memory read");

  // the count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count above capacity");
`endif

endmodule

[hdl/deq_ram.sv]
// ----------------------------------------------------------------------------
// deq_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
